// ===== hdl/tsr_pkg.sv =====
// Shared constants, codes and types of the tunnel session resequencer.
`default_nettype none

package tsr_pkg;

   localparam int KIND_W     = 3;
   localparam int SLOT_W     = 4;
   localparam int SEQ_W      = 32;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 16;
   localparam int HND_W      = 16;
   localparam int STATUS_W   = 4;
   localparam int TICK_W     = 4;
   localparam int BYTES_W    = 20;
   localparam int ENTRIES_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_OPEN      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VALIDATE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESULT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 3'd6;
   localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd7;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OPENED    = 4'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_VALID     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_DELIVER   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_POLL      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_RESULT    = 4'd7;
   localparam logic [STATUS_W-1:0] ST_CLOSED    = 4'd8;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 4'd9;
   localparam logic [STATUS_W-1:0] ST_TICK_DONE = 4'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HS_LIMIT    = 2'd3;

   typedef struct packed {
      logic [ENTRIES_W-1:0] max_entries;
      logic [BYTES_W-1:0]   max_bytes;
      logic [TICK_W-1:0]    idle_limit;
      logic [TICK_W-1:0]    hs_limit;
   } csr_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   out_slot;
      logic [HND_W-1:0]    out_handle;
      logic [LEN_W-1:0]    out_len;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [HND_W-1:0] hnd;
      logic [LEN_W-1:0] len;
   } stash_type;

   function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
      return (v == {TICK_W{1'b1}}) ? v : v + TICK_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tsr_channels.sv =====
// Request and response channel interfaces.
`default_nettype none

interface tsr_req_if;
   import tsr_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SLOT_W-1:0]   slot;
   logic [SEQ_W-1:0]    seq;
   logic [ADDR_W-1:0]   peer_address;
   logic [LEN_W-1:0]    payload_len;
   logic [HND_W-1:0]    payload_handle;
   modport source (output valid, kind, slot, seq, peer_address, payload_len, payload_handle,
                   input ready);
   modport sink   (input valid, kind, slot, seq, peer_address, payload_len, payload_handle,
                   output ready);
endinterface

interface tsr_rsp_if;
   import tsr_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   out_slot;
   logic [HND_W-1:0]    out_handle;
   logic [LEN_W-1:0]    out_len;
   logic                last;
   modport source (output valid, status, out_slot, out_handle, out_len, last, input ready);
   modport sink   (input valid, status, out_slot, out_handle, out_len, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/tsr_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none

module tsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tsr_engine.sv =====
// Request sequencer: session table, stash scans, tick sweep and open search.
`default_nettype none

module tsr_engine #(
   parameter int SESSIONS    = 16,
   parameter int STASH_DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   tsr_req_if.sink          req,
   input  tsr_pkg::csr_type csr,
   output logic             res_valid,
   output tsr_pkg::rsp_type res,
   input  logic             res_ready
);

   import tsr_pkg::*;

   localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int DW = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
   localparam int CW = $clog2(STASH_DEPTH + 1);
   localparam int STASH_WORDS = SESSIONS * (1 << DW);

   typedef struct packed {
      logic [SEQ_W-1:0]       exp;
      logic [ADDR_W-1:0]      addr;
      logic [TICK_W-1:0]      idle;
      logic [TICK_W-1:0]      opn;
      logic [BYTES_W-1:0]     bytes;
      logic [CW-1:0]          cnt;
      logic [STASH_DEPTH-1:0] mask;
   } sess_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OPEN_SCAN, S_EXEC, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END,
      S_WB_EMIT, S_TICK_CHK, S_TICK_EVAL, S_TICK_DONE
   } state_type;

   state_type             state_ff;
   logic [SESSIONS-1:0]   live_ff;
   logic [SESSIONS-1:0]   hs_ff;
   logic [SW-1:0]         idx_ff;
   logic [DW-1:0]         j_ff;
   logic [DW-1:0]         free_ff;
   logic                  free_ok_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [SLOT_W-1:0]     oslot_ff;
   logic [SEQ_W-1:0]      seq_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [HND_W-1:0]      hnd_ff;
   sess_type              sess_ff;
   logic [STATUS_W-1:0]   st_ff;
   logic [HND_W-1:0]      pend_hnd_ff;
   logic [LEN_W-1:0]      pend_len_ff;
   logic                  wb_ff;
   logic                  store_ff;
   logic                  drain_ff;

   logic                  accept;
   logic [SW-1:0]         req_sidx;
   logic                  req_live;
   sess_type              sess_rd;
   sess_type              exec_sess;
   sess_type              tick_sess;
   logic                  tick_dead;
   logic                  idx_last;
   logic                  j_last;
   stash_type             stash_rd;
   logic                  scan_match;
   logic                  sess_re;
   logic [SW-1:0]         sess_raddr;
   logic                  sess_we;
   sess_type              sess_wdata;
   logic                  stash_re;
   logic                  stash_we;
   stash_type             stash_wdata;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign req_sidx  = SW'(req.slot);
   assign req_live  = (32'(req.slot) < 32'(SESSIONS)) && live_ff[req_sidx];
   assign idx_last  = (idx_ff == SW'(SESSIONS - 1));
   assign j_last    = (j_ff == DW'(STASH_DEPTH - 1));

   // result/data updates: idle cleared, sequence advanced on match; tick updates: idle and age saturate
   always_comb begin
      exec_sess      = sess_rd;
      exec_sess.idle = '0;
      if (sess_rd.exp == seq_ff) begin
         exec_sess.exp = sess_rd.exp + SEQ_W'(1);
      end
      tick_sess      = sess_rd;
      tick_sess.idle = sat_inc(sess_rd.idle);
      tick_sess.opn  = sat_inc(sess_rd.opn);
   end

   assign tick_dead = (sess_rd.idle > csr.idle_limit) ||
                      (!hs_ff[idx_ff] && (sess_rd.opn >= csr.hs_limit));
   assign scan_match = (stash_rd.seq == (drain_ff ? sess_ff.exp : seq_ff));

   // memory port control
   assign sess_re    = accept || ((state_ff == S_TICK_CHK) && live_ff[idx_ff]);
   assign sess_raddr = (state_ff == S_IDLE) ? req_sidx : idx_ff;
   assign sess_we    = ((state_ff == S_WB_EMIT) && wb_ff && res_ready) ||
                       ((state_ff == S_TICK_EVAL) && !tick_dead);
   assign sess_wdata = (state_ff == S_TICK_EVAL) ? tick_sess : sess_ff;
   assign stash_re   = (state_ff == S_SCAN_RD) && sess_ff.mask[j_ff];
   assign stash_we   = (state_ff == S_WB_EMIT) && store_ff && res_ready;
   assign stash_wdata = '{seq: seq_ff, hnd: hnd_ff, len: len_ff};

   tsr_ram #(.WIDTH($bits(sess_type)), .DEPTH(SESSIONS)) u_sess_ram (
      .clock      (clock),
      .we         (sess_we),
      .waddr      (idx_ff),
      .wdata      (sess_wdata),
      .re         (sess_re),
      .raddr      (sess_raddr),
      .rd_data_ff (sess_rd)
   );

   tsr_ram #(.WIDTH($bits(stash_type)), .DEPTH(STASH_WORDS)) u_stash_ram (
      .clock      (clock),
      .we         (stash_we),
      .waddr      ({idx_ff, free_ff}),
      .wdata      (stash_wdata),
      .re         (stash_re),
      .raddr      ({idx_ff, j_ff}),
      .rd_data_ff (stash_rd)
   );

   // result towards the output stage
   always_comb begin
      res_valid = 1'b0;
      res       = '{status: st_ff, out_slot: oslot_ff, out_handle: pend_hnd_ff,
                    out_len: pend_len_ff, last: 1'b1};
      unique case (state_ff)
         S_WB_EMIT: begin
            res_valid = 1'b1;
         end
         S_SCAN_CMP: begin
            res_valid  = drain_ff && scan_match;
            res.status = ST_DELIVER;
            res.last   = 1'b0;
         end
         S_TICK_EVAL: begin
            res_valid = tick_dead;
            res       = '{status: ST_CLOSED, out_slot: SLOT_W'(idx_ff), out_handle: '0,
                          out_len: '0, last: 1'b0};
         end
         S_TICK_DONE: begin
            res_valid = 1'b1;
            res       = '{status: ST_TICK_DONE, out_slot: '0, out_handle: '0,
                          out_len: '0, last: 1'b1};
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         hs_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff     <= req.kind;
                  oslot_ff    <= req.slot;
                  seq_ff      <= req.seq;
                  addr_ff     <= req.peer_address;
                  len_ff      <= req.payload_len;
                  hnd_ff      <= req.payload_handle;
                  pend_hnd_ff <= '0;
                  pend_len_ff <= '0;
                  wb_ff       <= 1'b0;
                  store_ff    <= 1'b0;
                  // open and tick sweep from slot 0
                  idx_ff      <= (req.kind == KIND_OPEN || req.kind == KIND_TICK) ?
                                 '0 : req_sidx;
                  if (req.kind == KIND_OPEN || req.kind == KIND_TICK) begin
                     state_ff <= (req.kind == KIND_OPEN) ? S_OPEN_SCAN : S_TICK_CHK;
                  end else if (req.kind == KIND_IGNORED) begin
                     state_ff <= S_IDLE;
                  end else if (!req_live) begin
                     st_ff    <= (req.kind == KIND_VALIDATE) ? ST_INVALID : ST_UNKNOWN;
                     state_ff <= S_WB_EMIT;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_OPEN_SCAN: begin
               if (!live_ff[idx_ff]) begin
                  live_ff[idx_ff] <= 1'b1;
                  hs_ff[idx_ff]   <= 1'b0;
                  sess_ff  <= '{exp: '0, addr: addr_ff, idle: '0, opn: '0, bytes: '0,
                                cnt: '0, mask: '0};
                  oslot_ff <= SLOT_W'(idx_ff);
                  st_ff    <= ST_OPENED;
                  wb_ff    <= 1'b1;
                  state_ff <= S_WB_EMIT;
               end else if (idx_last) begin
                  oslot_ff <= '0;
                  st_ff    <= ST_FULL;
                  state_ff <= S_WB_EMIT;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            S_EXEC: begin
               case (kind_ff)
                  KIND_VALIDATE: begin
                     st_ff    <= ((sess_rd.exp <= seq_ff) && (sess_rd.addr == addr_ff)) ?
                                 ST_VALID : ST_INVALID;
                     state_ff <= S_WB_EMIT;
                  end
                  KIND_REMOVE: begin
                     live_ff[idx_ff] <= 1'b0;
                     st_ff           <= ST_REMOVED;
                     state_ff        <= S_WB_EMIT;
                  end
                  KIND_HANDSHAKE: begin
                     hs_ff[idx_ff] <= 1'b1;
                     st_ff         <= ST_VALID;
                     state_ff      <= S_WB_EMIT;
                  end
                  KIND_RESULT: begin
                     sess_ff  <= exec_sess;
                     wb_ff    <= 1'b1;
                     st_ff    <= ST_RESULT;
                     state_ff <= S_WB_EMIT;
                  end
                  KIND_DATA: begin
                     sess_ff    <= exec_sess;
                     wb_ff      <= 1'b1;
                     j_ff       <= '0;
                     free_ok_ff <= 1'b0;
                     st_ff      <= ST_POLL;
                     if (sess_rd.exp == seq_ff) begin
                        drain_ff    <= 1'b1;
                        pend_hnd_ff <= hnd_ff;
                        pend_len_ff <= len_ff;
                        state_ff    <= S_SCAN_RD;
                     end else if ((32'(sess_rd.cnt) < 32'(csr.max_entries)) &&
                                  (32'(sess_rd.cnt) < 32'(STASH_DEPTH)) &&
                                  ((21'(sess_rd.bytes) + 21'(len_ff)) <= 21'(csr.max_bytes)))
                     begin
                        drain_ff <= 1'b0;
                        state_ff <= S_SCAN_RD;
                     end else begin
                        state_ff <= S_WB_EMIT;
                     end
                  end
                  default: begin
                     st_ff    <= ST_UNKNOWN;
                     state_ff <= S_WB_EMIT;
                  end
               endcase
            end
            S_SCAN_RD: begin
               if (sess_ff.mask[j_ff]) begin
                  state_ff <= S_SCAN_CMP;
               end else begin
                  if (!free_ok_ff) begin
                     free_ff    <= j_ff;
                     free_ok_ff <= 1'b1;
                  end
                  if (j_last) begin
                     state_ff <= S_SCAN_END;
                  end else begin
                     j_ff <= j_ff + DW'(1);
                  end
               end
            end
            S_SCAN_CMP: begin
               if (drain_ff && scan_match) begin
                  if (res_ready) begin
                     pend_hnd_ff         <= stash_rd.hnd;
                     pend_len_ff         <= stash_rd.len;
                     sess_ff.mask[j_ff]  <= 1'b0;
                     sess_ff.cnt         <= sess_ff.cnt - CW'(1);
                     sess_ff.bytes       <= sess_ff.bytes - BYTES_W'(stash_rd.len);
                     sess_ff.exp         <= sess_ff.exp + SEQ_W'(1);
                     j_ff                <= '0;
                     state_ff            <= S_SCAN_RD;
                  end
               end else if (scan_match) begin
                  // duplicate sequence: poll without storing
                  state_ff <= S_WB_EMIT;
               end else if (j_last) begin
                  state_ff <= S_SCAN_END;
               end else begin
                  j_ff     <= j_ff + DW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_END: begin
               if (drain_ff) begin
                  st_ff <= ST_DELIVER;
               end else begin
                  sess_ff.mask[free_ff] <= 1'b1;
                  sess_ff.cnt           <= sess_ff.cnt + CW'(1);
                  sess_ff.bytes         <= sess_ff.bytes + BYTES_W'(len_ff);
                  store_ff              <= 1'b1;
               end
               state_ff <= S_WB_EMIT;
            end
            S_WB_EMIT: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            S_TICK_CHK: begin
               if (live_ff[idx_ff]) begin
                  state_ff <= S_TICK_EVAL;
               end else if (idx_last) begin
                  state_ff <= S_TICK_DONE;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            S_TICK_EVAL: begin
               if (!tick_dead || res_ready) begin
                  if (tick_dead) begin
                     live_ff[idx_ff] <= 1'b0;
                  end
                  if (idx_last) begin
                     state_ff <= S_TICK_DONE;
                  end else begin
                     idx_ff   <= idx_ff + SW'(1);
                     state_ff <= S_TICK_CHK;
                  end
               end
            end
            S_TICK_DONE: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_no_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !res_valid)
      else $error("result offered while taking requests");

   a_request_starts_work: assert property (@(posedge clock) disable iff (reset)
      (accept && req.kind != KIND_IGNORED) |=> (state_ff != S_IDLE))
      else $error("accepted request did no work");

   a_compare_after_read: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN_CMP) && ($past(state_ff) != S_SCAN_CMP)) |-> $past(stash_re))
      else $error("stash compare without a preceding read");

   a_stash_count_bound: assert property (@(posedge clock) disable iff (reset)
      sess_we |-> (32'(sess_wdata.cnt) <= 32'(STASH_DEPTH)))
      else $error("stash count beyond depth");

endmodule

`default_nettype wire

// ===== hdl/tunnel_session_resequencer_top.sv =====
// Top level of the tunnel session resequencer: registers, sequencer and output stage.
`default_nettype none

// Session table with per-session resequencing. One request is worked on at a time;
// the request channel is ready again once all results of the previous request have
// gone into the output register. Session records live in a SESSIONS-deep RAM and
// out-of-order chunks in a RAM of (seq, handle, length) words, SESSIONS times
// STASH_DEPTH rounded up to a power of two deep, both with registered reads, so each
// step of the sequencer is a RAM read then a compare. Open searches the slots in turn
// from slot 0; tick visits every slot and evaluates the live ones; data in order
// rescans the stash for the next expected sequence after each release; data out of
// order scans the stash, when it has room, for a duplicate and a free entry. Each
// result waits whenever the consumer holds rsp_chan.ready low. Stashed payload bytes
// never pass through the block, only the buffer handles. Registers are to be written
// through the csr port only while no request is in flight; the block itself does not
// enforce this.
module tunnel_session_resequencer_top #(
   parameter int SESSIONS    = 16,
   parameter int STASH_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   tsr_req_if.sink                         req_chan,
   tsr_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [tsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import tsr_pkg::*;

   csr_type csr_ff;
   logic    res_valid;
   rsp_type res;
   logic    res_ready;
   logic    out_valid_ff;
   rsp_type out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{max_entries: 4'd8, max_bytes: 20'd65536, idle_limit: 4'd3,
                     hs_limit: 4'd1};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ENTRIES: csr_ff.max_entries <= csr_wdata[ENTRIES_W-1:0];
            CSR_MAX_BYTES:   csr_ff.max_bytes   <= csr_wdata[BYTES_W-1:0];
            CSR_IDLE_LIMIT:  csr_ff.idle_limit  <= csr_wdata[TICK_W-1:0];
            CSR_HS_LIMIT:    csr_ff.hs_limit    <= csr_wdata[TICK_W-1:0];
         endcase
      end
   end

   tsr_engine #(.SESSIONS(SESSIONS), .STASH_DEPTH(STASH_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_ff),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // output register: refills in the cycle it is taken
   assign res_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_ff.status;
   assign rsp_chan.out_slot   = out_ff.out_slot;
   assign rsp_chan.out_handle = out_ff.out_handle;
   assign rsp_chan.out_len    = out_ff.out_len;
   assign rsp_chan.last       = out_ff.last;

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("output register changed while stalled");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && !res.last) |=> !req_chan.ready)
      else $error("request taken before final result");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> res_ready)
      else $error("empty output stage refused a result");

endmodule

`default_nettype wire

// ===== sim/tunnel_session_resequencer_top_tb.sv =====
// Self-checking testbench for the tunnel session resequencer top level.
`default_nettype none

module tunnel_session_resequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsr_pkg::*;

   localparam int SESSIONS    = 16;
   localparam int STASH_DEPTH = 8;
   // cycles with no handshake on either channel before the run is abandoned
   localparam int STALL_LIMIT = 6000;
   // settle time after the last result: a full tick sweep plus margin
   localparam int SETTLE      = 120;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [SEQ_W-1:0]  seq;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [HND_W-1:0]  hnd;
   } request_t;

   // Session table predictor and store of expected responses.
   class session_scoreboard;
      logic [3:0]        max_entries = 4'd8;
      logic [19:0]       max_bytes   = 20'd65536;
      logic [3:0]        idle_limit  = 4'd3;
      logic [3:0]        hs_limit    = 4'd1;
      bit                live [SESSIONS];
      bit                hs_done [SESSIONS];
      logic [31:0]       exp_seq [SESSIONS];
      logic [31:0]       peer [SESSIONS];
      logic [3:0]        idle [SESSIONS];
      logic [3:0]        age [SESSIONS];
      int unsigned       held_bytes [SESSIONS];
      bit                st_valid [SESSIONS][STASH_DEPTH];
      logic [31:0]       st_seq [SESSIONS][STASH_DEPTH];
      logic [HND_W-1:0]  st_hnd [SESSIONS][STASH_DEPTH];
      logic [LEN_W-1:0]  st_len [SESSIONS][STASH_DEPTH];
      rsp_type           expected_rsp [$];
      int                errors = 0;

      function void set_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MAX_ENTRIES: max_entries = val[3:0];
            CSR_MAX_BYTES:   max_bytes   = val[19:0];
            CSR_IDLE_LIMIT:  idle_limit  = val[3:0];
            default:         hs_limit    = val[3:0];
         endcase
      endfunction

      function void drop_stash(int s);
         for (int k = 0; k < STASH_DEPTH; k++) st_valid[s][k] = 0;
         held_bytes[s] = 0;
      endfunction

      function int find_seq(int s, logic [31:0] q);
         for (int k = 0; k < STASH_DEPTH; k++)
            if (st_valid[s][k] && st_seq[s][k] == q) return k;
         return -1;
      endfunction

      function logic [3:0] bump(logic [3:0] v);
         return (v == 4'hF) ? v : v + 4'd1;
      endfunction

      function int live_count();
         int c = 0;
         for (int k = 0; k < SESSIONS; k++) c += live[k];
         return c;
      endfunction

      // Work out every response of one accepted request.
      function void note_request(request_t r);
         rsp_type out [$];
         int      s = r.slot;
         int      k, e, cnt, cap;
         bit      dead;
         if (r.kind == KIND_IGNORED) return;
         case (r.kind)
            KIND_OPEN: begin
               for (k = 0; k < SESSIONS; k++) if (!live[k]) break;
               if (k >= SESSIONS) out.push_back('{ST_FULL, 4'd0, 16'd0, 16'd0, 1'b0});
               else begin
                  live[k] = 1; hs_done[k] = 0; exp_seq[k] = '0; peer[k] = r.addr;
                  idle[k] = '0; age[k] = '0; drop_stash(k);
                  out.push_back('{ST_OPENED, 4'(k), 16'd0, 16'd0, 1'b0});
               end
            end
            KIND_TICK: begin
               for (k = 0; k < SESSIONS; k++) begin
                  if (!live[k]) continue;
                  dead = idle[k] > idle_limit;
                  if (!dead && !hs_done[k] && age[k] >= hs_limit) dead = 1;
                  if (dead) begin
                     live[k] = 0; drop_stash(k);
                     out.push_back('{ST_CLOSED, 4'(k), 16'd0, 16'd0, 1'b0});
                  end else begin
                     idle[k] = bump(idle[k]); age[k] = bump(age[k]);
                  end
               end
               out.push_back('{ST_TICK_DONE, 4'd0, 16'd0, 16'd0, 1'b0});
            end
            KIND_VALIDATE: begin
               out.push_back('{(live[s] && exp_seq[s] <= r.seq && peer[s] == r.addr) ?
                               ST_VALID : ST_INVALID, r.slot, 16'd0, 16'd0, 1'b0});
            end
            default: begin
               if (!live[s]) out.push_back('{ST_UNKNOWN, r.slot, 16'd0, 16'd0, 1'b0});
               else if (r.kind == KIND_REMOVE) begin
                  live[s] = 0; drop_stash(s);
                  out.push_back('{ST_REMOVED, r.slot, 16'd0, 16'd0, 1'b0});
               end else if (r.kind == KIND_HANDSHAKE) begin
                  hs_done[s] = 1;
                  out.push_back('{ST_VALID, r.slot, 16'd0, 16'd0, 1'b0});
               end else if (r.kind == KIND_RESULT) begin
                  idle[s] = '0;
                  if (exp_seq[s] == r.seq) exp_seq[s] = exp_seq[s] + 32'd1;
                  out.push_back('{ST_RESULT, r.slot, 16'd0, 16'd0, 1'b0});
               end else begin
                  idle[s] = '0;
                  if (exp_seq[s] == r.seq) begin
                     exp_seq[s] = exp_seq[s] + 32'd1;
                     out.push_back('{ST_DELIVER, r.slot, r.hnd, r.len, 1'b0});
                     // release stashed successors in order
                     for (int it = 0; it < STASH_DEPTH; it++) begin
                        e = find_seq(s, exp_seq[s]);
                        if (e < 0) break;
                        out.push_back('{ST_DELIVER, r.slot, st_hnd[s][e], st_len[s][e], 1'b0});
                        held_bytes[s] -= st_len[s][e];
                        st_valid[s][e] = 0;
                        exp_seq[s] = exp_seq[s] + 32'd1;
                     end
                  end else begin
                     cnt = 0;
                     for (k = 0; k < STASH_DEPTH; k++) cnt += st_valid[s][k];
                     cap = (max_entries < STASH_DEPTH) ? max_entries : STASH_DEPTH;
                     if (cnt < cap && held_bytes[s] + r.len <= max_bytes &&
                         find_seq(s, r.seq) < 0) begin
                        for (k = 0; k < STASH_DEPTH; k++) if (!st_valid[s][k]) begin
                           st_valid[s][k] = 1; st_seq[s][k] = r.seq;
                           st_hnd[s][k] = r.hnd; st_len[s][k] = r.len;
                           held_bytes[s] += r.len;
                           break;
                        end
                     end
                     out.push_back('{ST_POLL, r.slot, 16'd0, 16'd0, 1'b0});
                  end
               end
            end
         endcase
         out[out.size()-1].last = 1'b1;
         foreach (out[i]) expected_rsp.push_back(out[i]);
      endfunction

      task report(string what, logic [19:0] got, logic [19:0] want);
         errors++;
         $display("mismatch %s: got %0h want %0h", what, got, want);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report("unexpected response", got.status, '0);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status != want.status)         report("status", got.status, want.status);
         if (got.out_slot != want.out_slot)     report("slot", got.out_slot, want.out_slot);
         if (got.out_handle != want.out_handle) report("handle", got.out_handle, want.out_handle);
         if (got.out_len != want.out_len)       report("length", got.out_len, want.out_len);
         if (got.last != want.last)             report("last", got.last, want.last);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tsr_req_if req_chan ();
   tsr_rsp_if rsp_chan ();

   tunnel_session_resequencer_top #(.SESSIONS(SESSIONS), .STASH_DEPTH(STASH_DEPTH)) dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we, .csr_index, .csr_wdata
   );

   session_scoreboard sb = new();

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.kind, req_chan.slot, req_chan.seq} = '0;
      {req_chan.peer_address, req_chan.payload_len, req_chan.payload_handle} = '0;
   end

   // Monitor: both channels sampled at the rising edge; watchdog on quiet cycles.
   int quiet = 0;
   always @(posedge clock) begin
      if (!reset) begin
         quiet++;
         if (req_chan.valid && req_chan.ready) begin
            quiet = 0;
            sb.note_request('{req_chan.kind, req_chan.slot, req_chan.seq,
                              req_chan.peer_address, req_chan.payload_len,
                              req_chan.payload_handle});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            quiet = 0;
            sb.check_response('{rsp_chan.status, rsp_chan.out_slot, rsp_chan.out_handle,
                                rsp_chan.out_len, rsp_chan.last});
         end
         if (quiet >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Response sink: stretches of steady, patchy or sparse ready, plus one long hold.
   bit hold_req = 0;
   initial begin
      int hold_left;
      int stretch;
      int mode;
      hold_left = 0;
      stretch = 0;
      mode = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_left = 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(10, 80);
               mode = $urandom_range(0, 2);
            end
            stretch--;
            case (mode)
               0:       rsp_chan.ready = 1'b1;
               1:       rsp_chan.ready = $urandom_range(0, 1);
               default: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   int burst_left = 0;

   // Offer one request and hold it until accepted; gaps fall between bursts.
   task automatic send(request_t r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.kind = r.kind;
      req_chan.slot = r.slot;
      req_chan.seq = r.seq;
      req_chan.peer_address = r.addr;
      req_chan.payload_len = r.len;
      req_chan.payload_handle = r.hnd;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.set_csr(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(int ent, int bytes, int idl, int hs);
      write_csr(CSR_MAX_ENTRIES, CSR_DATA_W'(ent));
      write_csr(CSR_MAX_BYTES, CSR_DATA_W'(bytes));
      write_csr(CSR_IDLE_LIMIT, CSR_DATA_W'(idl));
      write_csr(CSR_HS_LIMIT, CSR_DATA_W'(hs));
   endtask

   function automatic request_t mk(logic [KIND_W-1:0] k, int s, logic [31:0] q,
                                   logic [31:0] a, logic [15:0] l, logic [15:0] h);
      request_t r;
      r.kind = k; r.slot = 4'(s); r.seq = q; r.addr = a; r.len = l; r.hnd = h;
      return r;
   endfunction

   // Random request, mostly well-formed against the current table.
   function automatic request_t pick();
      request_t r;
      int       s, roll;
      r.kind = KIND_IGNORED;
      r.slot = 4'($urandom_range(0, 15));
      r.seq = $urandom();
      r.addr = $urandom();
      r.len = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
      r.hnd = 16'($urandom());
      // aim at a live session most of the time
      if ($urandom_range(0, 9) != 0)
         for (int t = 0; t < 8; t++) begin
            s = $urandom_range(0, SESSIONS - 1);
            if (sb.live[s]) begin
               r.slot = 4'(s);
               break;
            end
         end
      s = r.slot;
      roll = $urandom_range(0, 99);
      if (sb.live_count() < 3 && roll < 50) r.kind = KIND_OPEN;
      else if (roll < 8)  r.kind = KIND_OPEN;
      else if (roll < 12) r.kind = KIND_REMOVE;
      else if (roll < 20) r.kind = KIND_VALIDATE;
      else if (roll < 60) r.kind = KIND_DATA;
      else if (roll < 70) r.kind = KIND_RESULT;
      else if (roll < 78) r.kind = KIND_TICK;
      else if (roll < 92) r.kind = KIND_HANDSHAKE;
      else if (roll < 94) r.kind = KIND_IGNORED;
      else r.kind = KIND_DATA;
      if (sb.live[s] && $urandom_range(0, 9) != 0) begin
         if (r.kind == KIND_DATA || r.kind == KIND_RESULT)
            r.seq = sb.exp_seq[s] + 32'($urandom_range(0, 4));
         if (r.kind == KIND_VALIDATE) begin
            r.seq = sb.exp_seq[s] + 32'($urandom_range(0, 3)) - 32'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) r.addr = sb.peer[s];
         end
      end
      return r;
   endfunction

   int sent = 0;

   task automatic random_run(int count);
      request_t r;
      while (count > 0) begin
         r = pick();
         send(r);
         if (r.kind != KIND_IGNORED) begin
            count--;
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, open, handshake, validate, stash, release, reap.
      send(mk(KIND_OPEN, 0, 0, 32'h0000_0000, 0, 0));
      send(mk(KIND_OPEN, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      send(mk(KIND_HANDSHAKE, 0, 0, 0, 0, 0));
      send(mk(KIND_VALIDATE, 0, 0, 32'h0000_0000, 0, 0));
      send(mk(KIND_VALIDATE, 0, 5, 32'h0000_0001, 0, 0));
      send(mk(KIND_RESULT, 0, 0, 0, 0, 0));
      send(mk(KIND_VALIDATE, 0, 0, 32'h0000_0000, 0, 0));      // seq below expected
      send(mk(KIND_DATA, 0, 3, 0, 16'hFFFF, 16'h1234));
      send(mk(KIND_DATA, 0, 2, 0, 16'd100, 16'hFFFF));
      send(mk(KIND_DATA, 0, 2, 0, 16'd7, 16'hABCD));            // seq 2 again; not in stash, byte limit refuses it
      send(mk(KIND_DATA, 0, 32'hFFFF_FFFF, 0, 16'd0, 16'd0));
      send(mk(KIND_DATA, 0, 1, 0, 16'd0, 16'h0000));            // delivers 1; 2 missing, so 3 stays stashed
      send(mk(KIND_REMOVE, 1, 0, 0, 0, 0));
      send(mk(KIND_REMOVE, 1, 0, 0, 0, 0));                     // dead slot
      send(mk(KIND_DATA, 9, 0, 0, 5, 5));
      send(mk(KIND_VALIDATE, 9, 0, 0, 0, 0));
      send(mk(KIND_IGNORED, 3, 0, 0, 0, 0));
      send(mk(KIND_OPEN, 0, 0, 32'hA5A5_5A5A, 0, 0));
      send(mk(KIND_TICK, 0, 0, 0, 0, 0));
      send(mk(KIND_TICK, 0, 0, 0, 0, 0));                       // reaps unfinished handshake
      send(mk(KIND_TICK, 0, 0, 0, 0, 0));
      send(mk(KIND_TICK, 0, 0, 0, 0, 0));
      send(mk(KIND_TICK, 0, 0, 0, 0, 0));                       // reaps idle session
      random_run(40);
      drain();

      // Most permissive limits; fill the table to see it refuse an open.
      configure(15, 20'hFFFFF, 15, 15);
      for (int i = 0; i < 17; i++) send(mk(KIND_OPEN, 0, 0, $urandom(), 0, 0));
      hold_req = 1;                    // sink holds off while requests pile up
      random_run(50);
      drain();

      // Tightest limits: nothing stashed, sessions without a handshake reaped on the first tick.
      configure(0, 0, 0, 0);
      random_run(45);
      drain();

      // Middling limits; a mid-phase pause lets the block run dry.
      configure(3, 5000, 2, 4);
      random_run(30);
      drain();
      random_run(30);
      drain();

      configure(8, 65536, 3, 1);
      random_run(30);
      drain();
      configure($urandom_range(1, 15), $urandom_range(0, 20'hFFFFF),
                $urandom_range(0, 15), $urandom_range(0, 15));
      random_run(30);
      drain();

      if (sb.errors == 0 && sb.expected_rsp.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
